// ----- rtl/core/bitmap_page_frame_allocator_top_defines.svh -----
// Assertion macros for the bitmap page frame allocator.
// Used by the top level; no other dependencies.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BPFA_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BPFA_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BPFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/bpfa_pkg.sv -----
// Shared types and constants for the bitmap page frame allocator.
// No dependencies.
package bpfa_pkg;
	localparam int DEF_PAGE_COUNT = 8192;
	localparam int DEF_PAGE_BYTES = 4096;
	// Page count of one request never exceeds 2^32 / 256 pages.
	localparam int NEED_W = 25;

	typedef enum logic [2:0] {
		REQ_ADD_FREE = 3'd0,
		REQ_RESERVE  = 3'd1,
		REQ_ALLOC    = 3'd2,
		REQ_PAGE     = 3'd3,
		REQ_FREE     = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOMEM     = 2'd1,
		ST_UNALIGNED = 2'd2
	} status_t;

	typedef struct packed {
		logic              hit;
		logic [2:0]        hit_bit;
		logic [NEED_W-1:0] carry;
	} scan_res_t;
endpackage

// ----- rtl/core/bpfa_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies.
module bpfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/bpfa_run_scan.sv -----
// One bitmap word of the first-fit run search.
// Depends on bpfa_pkg.
module bpfa_run_scan (
	input  logic [7:0]                   word,
	input  logic [bpfa_pkg::NEED_W-1:0]  carry_in,
	input  logic [bpfa_pkg::NEED_W-1:0]  need,
	output bpfa_pkg::scan_res_t          res
);
	localparam int NW = bpfa_pkg::NEED_W;

	always_comb begin
		logic [3:0]  r;
		logic [3:0]  run [8];
		logic [NW:0] tot;
		logic [NW:0] s;
		logic [7:0]  hit_v;
		r = 4'd0;
		for (int b = 0; b < 8; b++) begin
			r = word[b] ? r + 4'd1 : 4'd0;
			run[b] = r;
		end
		// run ending at bit b, continued from earlier words when unbroken
		for (int b = 0; b < 8; b++) begin
			tot = (run[b] == 4'(b + 1)) ? {1'b0, carry_in} + (NW+1)'(run[b])
				: (NW+1)'(run[b]);
			hit_v[b] = word[b] && (tot >= {1'b0, need});
		end
		res.hit = |hit_v;
		res.hit_bit = 3'd0;
		for (int b = 7; b >= 0; b--) begin
			if (hit_v[b]) begin
				res.hit_bit = 3'(b);
			end
		end
		s = {1'b0, carry_in} + (NW+1)'(8);
		if (run[7] == 4'd8) begin
			res.carry = (s >= {1'b0, need}) ? need : s[NW-1:0];
		end else begin
			res.carry = NW'(run[7]);
		end
	end
endmodule

// ----- rtl/core/bitmap_page_frame_allocator_top.sv -----
// Bitmap page frame allocator, first fit: one bit per page, 1 = free.
// Operation: range requests and frees read and rewrite each bitmap word they touch,
// requests that touch nothing go straight to the result; alloc requests scan one bitmap
// word per cycle from word 0 until a run fits or the last word is scanned, then reserve the run.
// Throughput: one request at a time, bound by the single RAM read port.
// Reset: a clearing pass writes every bitmap word to reserved, one word per
// cycle; no request is taken until it ends.
`include "bitmap_page_frame_allocator_top_defines.svh"
module bitmap_page_frame_allocator_top #(
	parameter int PAGE_COUNT = bpfa_pkg::DEF_PAGE_COUNT,
	parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] byte_address, [63:32] byte_length
	input  logic [2:0]  s_tuser,   // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] page_address
	output logic [1:0]  m_tuser    // [1:0] status
);
	localparam int NW = bpfa_pkg::NEED_W;
	localparam int MAP_WORDS = (PAGE_COUNT + 7) / 8;
	localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PW = $clog2(PAGE_COUNT + 1);
	localparam int SH = $clog2(PAGE_BYTES);
	localparam logic [31:0] OFF_MASK = 32'(PAGE_BYTES - 1);
	localparam logic [WW:0] LAST_WORD = (WW+1)'(MAP_WORDS - 1);

	typedef enum logic [2:0] {CLEAR, IDLE, SCAN, MARK, FIN} state_t;

	state_t               state_q;
	logic [WW:0]          rd_q;      // next word to read
	logic [WW:0]          last_q;    // last word of the walk
	logic                 rv_s1;     // read data valid
	logic [WW-1:0]        w_s1;      // word index of read data
	logic [PW-1:0]        first_q;   // marked range [first_q, end_q)
	logic [PW-1:0]        end_q;
	logic                 set_q;     // mark free (1) or reserved (0)
	logic [NW-1:0]        need_q;
	logic [NW-1:0]        carry_q;
	logic [31:0]          res_addr_q;
	bpfa_pkg::status_t    res_st_q;
	logic                 m_tvalid_q;
	logic [31:0]          m_addr_q;
	bpfa_pkg::status_t    m_st_q;

	logic [7:0]           rdata;
	logic [7:0]           wmask;
	logic                 we;
	logic [WW-1:0]        waddr;
	logic [7:0]           wdata;
	logic                 issue;
	bpfa_pkg::scan_res_t  sres;

	// request decode
	logic [31:0]          in_addr;
	logic [31:0]          in_len;
	logic                 in_unal;
	logic [33:0]          d_first;
	logic [33:0]          d_cnt;
	logic [33:0]          d_end;
	logic [33:0]          d_need;
	logic                 d_mark;

	// hit decode
	logic [33:0]          h_end;
	logic [33:0]          h_start;
	logic [63:0]          h_addr;

	assign in_addr = s_tdata[31:0];
	assign in_len  = s_tdata[63:32];
	assign in_unal = (in_addr & OFF_MASK) != 32'd0;

	always_comb begin
		d_first = 34'(in_addr >> SH);
		d_cnt = 34'd0;
		d_mark = 1'b0;
		unique case (s_tuser)
			bpfa_pkg::REQ_ADD_FREE: begin
				d_cnt = 34'(in_len >> SH);
				// skip a partial first page
				if (d_cnt != 34'd0 && in_unal) begin
					d_first = d_first + 34'd1;
					d_cnt = d_cnt - 34'd1;
				end
				d_mark = 1'b1;
			end
			bpfa_pkg::REQ_RESERVE: begin
				d_cnt = ({2'b0, in_len} + 34'(PAGE_BYTES - 1)) >> SH;
				d_mark = 1'b1;
			end
			bpfa_pkg::REQ_FREE: begin
				d_cnt = 34'd1;
				d_mark = !in_unal;
			end
			default: begin
				d_mark = 1'b0;
			end
		endcase
		d_end = d_first + d_cnt;
		if (d_end > 34'(PAGE_COUNT)) begin
			d_end = 34'(PAGE_COUNT);
		end
		// nothing to mark when the clipped range is empty
		if (d_first >= d_end) begin
			d_mark = 1'b0;
		end
		d_need = ({2'b0, in_len} + 34'(PAGE_BYTES - 1)) >> SH;
		if (s_tuser == bpfa_pkg::REQ_PAGE || d_need == 34'd0) begin
			d_need = 34'd1;
		end
	end

	bpfa_run_scan u_scan (
		.word     (rdata),
		.carry_in (carry_q),
		.need     (need_q),
		.res      (sres)
	);

	assign h_end   = 34'({w_s1, sres.hit_bit});
	assign h_start = h_end + 34'd1 - 34'(need_q);
	assign h_addr  = 64'(h_start) << SH;

	// bits of word w_s1 inside the marked range
	always_comb begin
		logic [33:0] pg;
		for (int b = 0; b < 8; b++) begin
			pg = 34'({w_s1, 3'(b)});
			wmask[b] = (pg >= 34'(first_q)) && (pg < 34'(end_q));
		end
	end

	always_comb begin
		issue = 1'b0;
		if (state_q == MARK) begin
			issue = rd_q <= last_q;
		end else if (state_q == SCAN) begin
			issue = (rd_q <= last_q) && !(rv_s1 && sres.hit);
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = w_s1;
		wdata = set_q ? (rdata | wmask) : (rdata & ~wmask);
		if (state_q == CLEAR) begin
			we = 1'b1;
			waddr = rd_q[WW-1:0];
			wdata = 8'd0;
		end else if (state_q == MARK && rv_s1) begin
			we = 1'b1;
		end
	end

	bpfa_ram #(.WIDTH(8), .DEPTH(MAP_WORDS)) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_q[WW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CLEAR;
			rd_q       <= '0;
			last_q     <= '0;
			rv_s1      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rv_s1 <= issue;
			w_s1  <= rd_q[WW-1:0];
			if (issue) begin
				rd_q <= rd_q + (WW+1)'(1);
			end
			// load a finished result when the output register frees up, else drop a taken beat
			if (state_q == FIN && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					// sweep every word to reserved
					if (rd_q == LAST_WORD) begin
						rd_q <= '0;
						state_q <= IDLE;
					end else begin
						rd_q <= rd_q + (WW+1)'(1);
					end
				end
				IDLE: begin
					if (s_tvalid) begin
						res_addr_q <= 32'd0;
						res_st_q <= bpfa_pkg::ST_OK;
						if (s_tuser == bpfa_pkg::REQ_ALLOC || s_tuser == bpfa_pkg::REQ_PAGE) begin
							need_q <= NW'(d_need);
							carry_q <= '0;
							rd_q <= '0;
							last_q <= LAST_WORD;
							state_q <= SCAN;
						end else if (d_mark) begin
							first_q <= PW'(d_first);
							end_q <= PW'(d_end);
							set_q <= s_tuser != bpfa_pkg::REQ_RESERVE;
							rd_q <= (WW+1)'(d_first >> 3);
							last_q <= (WW+1)'((d_end - 34'd1) >> 3);
							state_q <= MARK;
						end else begin
							if (s_tuser == bpfa_pkg::REQ_FREE && in_unal) begin
								res_st_q <= bpfa_pkg::ST_UNALIGNED;
							end
							state_q <= FIN;
						end
					end
				end
				SCAN: begin
					if (rv_s1) begin
						carry_q <= sres.carry;
						if (sres.hit) begin
							// reserve the run that ends at the hit bit
							first_q <= PW'(h_start);
							end_q <= PW'(h_end + 34'd1);
							set_q <= 1'b0;
							rd_q <= (WW+1)'(h_start >> 3);
							last_q <= {1'b0, w_s1};
							res_addr_q <= h_addr[31:0];
							state_q <= MARK;
						end else if ({1'b0, w_s1} == LAST_WORD) begin
							res_st_q <= bpfa_pkg::ST_NOMEM;
							state_q <= FIN;
						end
					end
				end
				MARK: begin
					if (rv_s1 && {1'b0, w_s1} == last_q) begin
						state_q <= FIN;
					end
				end
				FIN: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_addr_q <= res_addr_q;
						m_st_q <= res_st_q;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_addr_q;
	assign m_tuser  = m_st_q;

	`BPFA_ASSERT_IMPLY(a_we_state, we, (state_q == CLEAR || state_q == MARK), "RAM write outside clear or mark")
	`BPFA_ASSERT_IMPLY(a_mark_range, (state_q == MARK && we), ({1'b0, w_s1} <= last_q), "mark write past last word")
	`BPFA_ASSERT_IMPLY(a_unal_zero, (m_tvalid && m_tuser == bpfa_pkg::ST_UNALIGNED), (m_tdata == 32'd0), "unaligned free returned an address")
	`BPFA_ASSERT_NEXT(a_fin_out, (state_q == FIN && (!m_tvalid || m_tready)), (m_tvalid && state_q == IDLE), "finished result not presented")
endmodule
